[hw/rtl/cpst_pkg.sv]
package cpst_pkg;

  localparam int COORD_W = 8;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MEMBER  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DROP_AT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pair_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [COORD_W-1:0] x_out;
    logic [COORD_W-1:0] y_out;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

[hw/rtl/cpst_cell.sv]
module cpst_cell (
  input  logic                  clk,
  input  cpst_pkg::cell_ctrl_t  ctrl,
  input  cpst_pkg::pair_t       cmp_pair,
  input  cpst_pkg::pair_t       prev_pair,
  input  cpst_pkg::pair_t       next_pair,
  input  logic                  drop,
  output cpst_pkg::pair_t       pair,
  output logic                  match
);

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match <= (pair == cmp_pair);
    end
    if (ctrl.ins) begin
      pair <= prev_pair;
    end else if (ctrl.del && drop) begin
      pair <= next_pair;
    end
  end

endmodule

[hw/rtl/coordinate_pair_set_table.sv]
// The request is compared at the accepting edge and applied in S_APPLY; out_valid rises
// at the edge that leaves S_APPLY, together with the registered result.
// The cell row compares all entries at acceptance and shifts in the following cycle,
// so the next request waits for that: in_stall holds it off while in S_APPLY.
// A result held by out_stall also holds off the next request.
// Reset (rst, synchronous): table empty, count zero, no result pending.
// Entry storage has no reset; only entries below the count are ever visible.
module coordinate_pair_set_table #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cpst_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cpst_pkg::rsp_t   out_data
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IW   = (CNTW > cpst_pkg::POS_W) ? CNTW : cpst_pkg::POS_W;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic                 state;
  logic [CNTW-1:0]      count;
  logic [CNTW-1:0]      count_next;
  cpst_pkg::req_t       req_q;
  cpst_pkg::pair_t      in_pair;
  cpst_pkg::pair_t      req_pair;
  cpst_pkg::pair_t      cell_pair [DEPTH];
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     live;
  logic [DEPTH-1:0]     idx_eq;
  logic [DEPTH-1:0]     hit;
  logic [DEPTH-1:0]     hit_dec;
  logic [DEPTH-1:0]     onehot;
  logic [DEPTH-1:0]     ge_mask;
  logic                 any_hit;
  logic                 idx_ok;
  logic                 accept;
  logic                 apply;
  cpst_pkg::cell_ctrl_t ctrl;
  cpst_pkg::pair_t      sel_pair;
  cpst_pkg::rsp_t       rsp;

  assign accept   = in_valid && !in_stall;
  assign apply    = (state == S_APPLY);
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  assign in_pair.x  = in_data.x_coord;
  assign in_pair.y  = in_data.y_coord;
  assign req_pair.x = req_q.x_coord;
  assign req_pair.y = req_q.y_coord;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cpst_pkg::pair_t prev_p;
      cpst_pkg::pair_t next_p;

      if (gi == 0) begin : g_head
        assign prev_p = req_pair;
      end else begin : g_mid
        assign prev_p = cell_pair[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign next_p = cell_pair[gi];
      end else begin : g_body
        assign next_p = cell_pair[gi+1];
      end

      assign live[gi]   = (CNTW'(gi) < count);
      assign idx_eq[gi] = (IW'(req_q.position) == IW'(gi));

      cpst_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .cmp_pair  (in_pair),
        .prev_pair (prev_p),
        .next_pair (next_p),
        .drop      (ge_mask[gi]),
        .pair      (cell_pair[gi]),
        .match     (match[gi])
      );
    end
  endgenerate

  always_comb begin
    case (req_q.req_type) inside
      cpst_pkg::REQ_REMOVE, cpst_pkg::REQ_MEMBER: hit = match & live;
      cpst_pkg::REQ_READ, cpst_pkg::REQ_DROP_AT:  hit = idx_eq;
      default:                                    hit = '0;
    endcase
  end

  // lowest set bit is the newest hit; ge_mask covers it and every older entry
  assign hit_dec = hit - DEPTH'(1);
  assign onehot  = hit & ~hit_dec;
  assign ge_mask = ~((hit ^ hit_dec) >> 1);
  assign any_hit = |hit;
  assign idx_ok  = (IW'(req_q.position) < IW'(count));

  always_comb begin
    sel_pair = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_pair = sel_pair | (onehot[i] ? cell_pair[i] : '0);
    end
  end

  always_comb begin
    ctrl       = '0;
    ctrl.cmp   = accept;
    count_next = count;
    rsp        = '0;
    case (req_q.req_type)
      cpst_pkg::REQ_ADD: begin
        if (count == CNTW'(DEPTH)) begin
          rsp.status = cpst_pkg::ST_FULL;
        end else begin
          ctrl.ins   = apply;
          count_next = count + CNTW'(1);
        end
      end
      cpst_pkg::REQ_REMOVE: begin
        if (any_hit) begin
          ctrl.del   = apply;
          rsp.found  = 1'b1;
          count_next = count - CNTW'(1);
        end
      end
      cpst_pkg::REQ_MEMBER: begin
        rsp.found = any_hit;
      end
      cpst_pkg::REQ_READ, cpst_pkg::REQ_DROP_AT: begin
        if (!idx_ok) begin
          rsp.status = cpst_pkg::ST_RANGE;
        end else begin
          rsp.x_out = sel_pair.x;
          rsp.y_out = sel_pair.y;
          if (req_q.req_type == cpst_pkg::REQ_DROP_AT) begin
            ctrl.del   = apply;
            rsp.found  = 1'b1;
            count_next = count - CNTW'(1);
          end
        end
      end
      cpst_pkg::REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    rsp.count = cpst_pkg::COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= in_data;
    end
    if (apply) begin
      out_data <= rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_APPLY;
          end
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_APPLY: begin
          count     <= count_next;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
